@@ rtl/poly_sigmoid_logreg_gd_step_assert.svh @@
// Assertion macros for the top-level RTL file
`ifndef POLY_SIGMOID_LOGREG_GD_STEP_ASSERT_SVH
`define POLY_SIGMOID_LOGREG_GD_STEP_ASSERT_SVH

`ifndef SYNTH
`define PSL_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psl: implication check failed");
`define PSL_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psl: next-cycle check failed");
`else
`define PSL_AST_IMP(lbl, ante, cons)
`define PSL_AST_NXT(lbl, ante, cons)
`endif

`endif

@@ rtl/psl_pkg.sv @@
package psl_pkg;

	localparam logic [1:0] OP_FEAT = 2'd0;
	localparam logic [1:0] OP_EOB  = 2'd1;
	localparam logic [1:0] OP_CLR  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic [1:0] MODE_MOM = 2'd1;
	localparam logic [1:0] MODE_NES = 2'd2;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_STEP = 3'd1;
	localparam logic [2:0] CFG_ETA  = 3'd2;
	localparam logic [2:0] CFG_C0   = 3'd3;
	localparam logic [2:0] CFG_C1   = 3'd4;
	localparam logic [2:0] CFG_C3   = 3'd5;
	localparam logic [2:0] CFG_C5   = 3'd6;
	localparam logic [2:0] CFG_C7   = 3'd7;

	localparam logic signed [32:0] QONE = 33'sd16777216;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] feature_value;
		logic               last_feature;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         weight_index;
		logic signed [31:0] weight_value;
		logic               last_weight;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] v;
		logic signed [47:0] gs;
		logic signed [31:0] sb;
	} cell_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FEAT,
		S_POLY,
		S_GRAD,
		S_ALIGN,
		S_UPD
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
		if (x > 68'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -68'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [67:0] x);
		if (x > 68'sd140737488355327) begin
			return 48'sh7fffffffffff;
		end else if (x < -68'sd140737488355328) begin
			return 48'sh800000000000;
		end
		return x[47:0];
	endfunction

	// round half up to Q.24
	function automatic logic signed [41:0] qrnd(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd8388608;
		return t[65:24];
	endfunction

endpackage

@@ rtl/psl_cell.sv @@
module psl_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          clr,
	input  psl_pkg::cell_t d,
	output psl_pkg::cell_t q
);
	import psl_pkg::*;

	logic signed [31:0] w_q;
	logic signed [31:0] v_q;
	logic signed [47:0] gs_q;
	logic signed [31:0] sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q  <= '0;
			v_q  <= '0;
			gs_q <= '0;
		end else if (shift) begin
			w_q  <= d.w;
			v_q  <= d.v;
			gs_q <= d.gs;
		end else if (clr) begin
			w_q <= '0;
			v_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			sb_q <= d.sb;
		end
	end

	assign q = '{w: w_q, v: v_q, gs: gs_q, sb: sb_q};

endmodule

@@ rtl/poly_sigmoid_logreg_gd_step.sv @@
// Logistic-regression batch gradient step, Q8.24.
// Sample channel (sample_valid / sample_stall / sample): op 0 carries one feature,
// op 1 ends the batch, op 2 clears weights and velocities. Items are taken
// only while the block is idle; sample_stall is high otherwise.
// Weight channel (weight_valid / weight_stall / weight): DIM results per end of
// batch, in index order, last_weight on the final one. A held result stalls
// the update walk until it is taken.
// Config channel: cfg_ready is always high; write only while idle.
// State sits in a ring of DIM cells that rotates past one shared 33x33
// multiplier at the head.
// Steps per item: a plain feature passes S_FEAT; a last feature then runs the
// polynomial, the gradient walk and the ring realignment, skipping S_FEAT when
// DIM features are already in; end of batch runs the realignment and then the
// update walk, which a held output stalls; clear is done in idle.
// The first weight follows the update steps of index 0, after ring realignment
// when a partial sample is pending; each further weight follows its own steps.
// Reset: weights, velocities and gradient sums zero, Nesterov mode,
// step size 1.0, other control and config registers zero, no result pending.
`include "poly_sigmoid_logreg_gd_step_assert.svh"

module poly_sigmoid_logreg_gd_step #(
	parameter int DIM = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  psl_pkg::in_item_t  sample,
	output logic               weight_valid,
	input  logic               weight_stall,
	output psl_pkg::out_item_t weight,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import psl_pkg::*;

	localparam int HW   = $clog2(DIM);
	localparam int CNTW = $clog2(DIM + 1);

	state_t state_q, state_d;

	logic [1:0]         mode_q;
	logic signed [31:0] step_q, eta_q, c0_q, c1_q, c3_q, c5_q, c7_q;

	cell_t cell_q [DIM];
	cell_t head_new;
	logic  shift, clr;

	logic [HW-1:0]   hd_q, hd_inc, ecnt_q, ecnt_inc;
	logic [CNTW-1:0] count_q;
	logic [3:0]      st_q;
	logic            upd_q, last_q;
	logic signed [47:0] dot_q;

	logic signed [31:0] f_q, x_q, x2_q, x3_q, x5_q, x7_q, p_q, g_q, t_q;
	logic signed [34:0] sum_q;
	logic signed [41:0] acc_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;

	logic signed [31:0] rs, x_c, t_c, wn, vn;
	logic               room, out_load, wvalid_q;
	out_item_t          out_q;

	genvar gi;
	generate
		for (gi = 0; gi < DIM; gi++) begin : g_ring
			if (gi == DIM - 1) begin : g_tail
				psl_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .clr(clr),
					.d(head_new), .q(cell_q[gi]));
			end else begin : g_body
				psl_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(shift), .clr(clr),
					.d(cell_q[gi+1]), .q(cell_q[gi]));
			end
		end
	endgenerate

	assign hd_inc   = (hd_q == HW'(DIM - 1)) ? '0 : hd_q + 1'b1;
	assign ecnt_inc = (ecnt_q == HW'(DIM - 1)) ? '0 : ecnt_q + 1'b1;

	assign rs   = sat32(68'(qrnd(prod_q)));
	assign x_c  = sat32(68'(dot_q));
	assign t_c  = sat32(68'(cell_q[0].v) - 68'(g_q));
	assign room = !wvalid_q || !weight_stall;

	always_comb begin
		case (mode_q)
			MODE_MOM: begin
				vn = sat32(68'(acc_q) + 68'(g_q));
				wn = sat32(68'(cell_q[0].w) - 68'(vn));
			end
			MODE_NES: begin
				vn = sat32(68'(acc_q) + 68'(qrnd(prod_q)));
				wn = t_q;
			end
			default: begin
				vn = cell_q[0].v;
				wn = sat32(68'(cell_q[0].w) - 68'(g_q));
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		shift    = 1'b0;
		clr      = 1'b0;
		head_new = cell_q[0];
		mul_a    = '0;
		mul_b    = '0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				mul_a = 33'(sample.feature_value);
				mul_b = (mode_q == MODE_NES) ? 33'(cell_q[0].v) : 33'(cell_q[0].w);
				if (sample_valid) begin
					case (sample.op)
						OP_FEAT: begin
							if (count_q < CNTW'(DIM)) begin
								state_d = S_FEAT;
							end else if (sample.last_feature) begin
								state_d = S_POLY;
							end
						end
						OP_EOB: state_d = S_ALIGN;
						OP_CLR: clr = 1'b1;
						default: ;
					endcase
				end
			end
			S_FEAT: begin
				shift       = 1'b1;
				head_new.sb = f_q;
				state_d     = last_q ? S_POLY : S_IDLE;
			end
			S_POLY: begin
				case (st_q)
					4'd0: begin mul_a = 33'(x_c);  mul_b = 33'(x_c);  end
					4'd2: begin mul_a = 33'(x2_q); mul_b = 33'(x_q);  end
					4'd4: begin mul_a = 33'(x3_q); mul_b = 33'(x2_q); end
					4'd6: begin mul_a = 33'(x5_q); mul_b = 33'(x2_q); end
					4'd8: begin mul_a = 33'(c1_q); mul_b = 33'(x_q);  end
					4'd10: begin mul_a = 33'(c3_q); mul_b = 33'(x3_q); end
					4'd12: begin mul_a = 33'(c5_q); mul_b = 33'(x5_q); end
					4'd14: begin mul_a = 33'(c7_q); mul_b = 33'(x7_q); end
					default: ;
				endcase
				if (st_q == 4'd15) begin
					state_d = S_GRAD;
				end
			end
			S_GRAD: begin
				mul_a = 33'(p_q);
				mul_b = 33'(cell_q[0].sb);
				if (st_q[0]) begin
					shift = 1'b1;
					// only features of this sample take part
					if (CNTW'(hd_q) < count_q) begin
						head_new.gs = sat48(68'(cell_q[0].gs) + 68'(qrnd(prod_q)));
					end
					if (ecnt_q == HW'(DIM - 1)) begin
						state_d = S_ALIGN;
					end
				end
			end
			S_ALIGN: begin
				if (hd_q == '0) begin
					state_d = upd_q ? S_UPD : S_IDLE;
				end else begin
					shift = 1'b1;
				end
			end
			S_UPD: begin
				case (st_q)
					4'd0: begin
						mul_a = {9'b0, cell_q[0].gs[23:0]};
						mul_b = 33'(step_q);
					end
					4'd1: begin
						mul_a = 33'($signed(cell_q[0].gs[47:24]));
						mul_b = 33'(step_q);
					end
					4'd3: begin
						mul_a = (mode_q == MODE_MOM) ? 33'(eta_q) : QONE - 33'(eta_q);
						mul_b = (mode_q == MODE_MOM) ? 33'(cell_q[0].v) : 33'(t_c);
					end
					4'd4, 4'd5: begin
						mul_a = 33'(eta_q);
						mul_b = 33'(cell_q[0].w);
					end
					default: ;
				endcase
				if (st_q == 4'd5 && room) begin
					out_load    = 1'b1;
					shift       = 1'b1;
					head_new.w  = wn;
					head_new.v  = vn;
					head_new.gs = '0;
					if (ecnt_q == HW'(DIM - 1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= MODE_NES;
			step_q   <= 32'sd16777216;
			eta_q    <= '0;
			c0_q     <= '0;
			c1_q     <= '0;
			c3_q     <= '0;
			c5_q     <= '0;
			c7_q     <= '0;
			hd_q     <= '0;
			ecnt_q   <= '0;
			count_q  <= '0;
			st_q     <= '0;
			upd_q    <= 1'b0;
			last_q   <= 1'b0;
			dot_q    <= '0;
			wvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[1:0];
					CFG_STEP: step_q <= cfg_data;
					CFG_ETA:  eta_q  <= cfg_data;
					CFG_C0:   c0_q   <= cfg_data;
					CFG_C1:   c1_q   <= cfg_data;
					CFG_C3:   c3_q   <= cfg_data;
					CFG_C5:   c5_q   <= cfg_data;
					CFG_C7:   c7_q   <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				wvalid_q <= 1'b1;
			end else if (!weight_stall) begin
				wvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					st_q <= '0;
					if (sample_valid) begin
						last_q <= sample.last_feature;
						if (sample.op == OP_EOB) begin
							// a partial sample is dropped
							count_q <= '0;
							dot_q   <= '0;
							upd_q   <= 1'b1;
						end
					end
				end
				S_FEAT: begin
					dot_q   <= sat48(68'(dot_q) + 68'(qrnd(prod_q)));
					hd_q    <= hd_inc;
					count_q <= count_q + 1'b1;
				end
				S_POLY: begin
					st_q   <= st_q + 1'b1;
					ecnt_q <= '0;
				end
				S_GRAD: begin
					st_q <= {3'b0, ~st_q[0]};
					if (st_q[0]) begin
						hd_q   <= hd_inc;
						ecnt_q <= ecnt_inc;
						if (ecnt_q == HW'(DIM - 1)) begin
							count_q <= '0;
							dot_q   <= '0;
							upd_q   <= 1'b0;
						end
					end
				end
				S_ALIGN: begin
					st_q   <= '0;
					ecnt_q <= '0;
					if (hd_q != '0) begin
						hd_q <= hd_inc;
					end
				end
				S_UPD: begin
					if (st_q == 4'd5) begin
						if (room) begin
							st_q   <= '0;
							hd_q   <= hd_inc;
							ecnt_q <= ecnt_inc;
						end
					end else begin
						st_q <= st_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_IDLE && sample_valid) begin
			f_q <= sample.feature_value;
		end
		if (state_q == S_POLY) begin
			case (st_q)
				4'd0:  x_q   <= x_c;
				4'd1:  x2_q  <= rs;
				4'd3:  x3_q  <= rs;
				4'd5:  x5_q  <= rs;
				4'd7:  x7_q  <= rs;
				4'd9:  sum_q <= 35'(c0_q) + 35'(rs);
				4'd11, 4'd13: sum_q <= sum_q + 35'(rs);
				4'd15: p_q   <= sat32(68'(sum_q) + 68'(rs));
				default: ;
			endcase
		end
		if (state_q == S_UPD) begin
			case (st_q)
				4'd1: acc_q <= qrnd(prod_q);
				4'd2: g_q   <= sat32(68'(acc_q) + 68'(prod_q));
				4'd3: t_q   <= t_c;
				4'd4: acc_q <= qrnd(prod_q);
				default: ;
			endcase
		end
		if (out_load) begin
			out_q <= '{weight_index: 4'(ecnt_q), weight_value: wn,
				last_weight: (ecnt_q == HW'(DIM - 1))};
		end
	end

	assign sample_stall = (state_q != S_IDLE);
	assign weight_valid = wvalid_q;
	assign weight       = out_q;
	assign cfg_ready    = 1'b1;

	// ring head index tracks the weight counter whenever the update walk runs
	`PSL_AST_IMP(a_upd_aligned, state_q == S_UPD, hd_q == ecnt_q)
	`PSL_AST_IMP(a_idle_head, state_q == S_IDLE,
		(CNTW'(hd_q) == count_q) || (count_q == CNTW'(DIM) && hd_q == '0))
	`PSL_AST_NXT(a_last_done, out_load && ecnt_q == HW'(DIM - 1), state_q == S_IDLE)
	`PSL_AST_IMP(a_load_room, out_load, state_q == S_UPD && room)

endmodule

@@ tb/sv/tb_poly_sigmoid_logreg_gd_step.sv @@
`timescale 1ns / 100ps

import psl_pkg::*;

class weight_scoreboard;
	localparam int N = 16;
	localparam longint HALF = 64'sd8388608;
	localparam longint ONE = 64'sd16777216;

	logic [1:0] mode;
	longint step, eta, c0, c1, c3, c5, c7;
	longint wts[N], vel[N], grad[N], fbuf[N];
	int unsigned nfeat;
	longint dot;
	out_item_t expected_weights[$];
	int errors;

	function new();
		mode = MODE_NES;
		step = ONE;
		eta = 0; c0 = 0; c1 = 0; c3 = 0; c5 = 0; c7 = 0;
		foreach (wts[i]) begin
			wts[i] = 0; vel[i] = 0; grad[i] = 0; fbuf[i] = 0;
		end
		nfeat = 0;
		dot = 0;
		errors = 0;
	endfunction

	function longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function longint sat48(longint x);
		if (x > 64'sd140737488355327) return 64'sd140737488355327;
		if (x < -64'sd140737488355328) return -64'sd140737488355328;
		return x;
	endfunction

	function longint qmul(longint a, longint b);
		return (a * b + HALF) >>> 24;
	endfunction

	// gradient sum is 48 bits wide, so split it to keep the product exact
	function longint qmul_wide(longint g, longint s);
		longint hi, lo;
		hi = g >>> 24;
		lo = g & 64'hFFFFFF;
		return hi * s + ((lo * s + HALF) >>> 24);
	endfunction

	function longint sigmoid_poly(longint x);
		longint x2, x3, x5, x7, s;
		x2 = sat32(qmul(x, x));
		x3 = sat32(qmul(x2, x));
		x5 = sat32(qmul(x3, x2));
		x7 = sat32(qmul(x5, x2));
		s = c0 + sat32(qmul(c1, x)) + sat32(qmul(c3, x3))
			+ sat32(qmul(c5, x5)) + sat32(qmul(c7, x7));
		return sat32(s);
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] data);
		longint sv;
		sv = longint'($signed(data));
		case (idx)
			CFG_MODE: mode = data[1:0];
			CFG_STEP: step = sv;
			CFG_ETA: eta = sv;
			CFG_C0: c0 = sv;
			CFG_C1: c1 = sv;
			CFG_C3: c3 = sv;
			CFG_C5: c5 = sv;
			CFG_C7: c7 = sv;
			default: ;
		endcase
	endfunction

	function void note_input(in_item_t it);
		longint f, m, p, g, w, v, t;
		out_item_t r;
		case (it.op)
			OP_FEAT: begin
				f = longint'(it.feature_value);
				if (nfeat < N) begin
					m = (mode == MODE_NES) ? vel[nfeat] : wts[nfeat];
					fbuf[nfeat] = f;
					dot = sat48(dot + qmul(f, m));
					nfeat++;
				end
				if (it.last_feature) begin
					p = sigmoid_poly(sat32(dot));
					for (int i = 0; i < nfeat; i++)
						grad[i] = sat48(grad[i] + qmul(p, fbuf[i]));
					nfeat = 0;
					dot = 0;
				end
			end
			OP_CLR: begin
				foreach (wts[i]) begin
					wts[i] = 0;
					vel[i] = 0;
				end
			end
			OP_EOB: begin
				for (int i = 0; i < N; i++) begin
					g = sat32(qmul_wide(grad[i], step));
					w = wts[i];
					v = vel[i];
					if (mode == MODE_MOM) begin
						v = sat32(qmul(eta, v) + g);
						w = sat32(w - v);
					end else if (mode == MODE_NES) begin
						t = sat32(v - g);
						v = sat32(qmul(ONE - eta, t) + qmul(eta, w));
						w = t;
					end else begin
						w = sat32(w - g);
					end
					wts[i] = w;
					vel[i] = v;
					grad[i] = 0;
					r.weight_index = i[3:0];
					r.weight_value = w[31:0];
					r.last_weight = (i == N - 1);
					expected_weights = {expected_weights, r};
				end
				nfeat = 0;
				dot = 0;
			end
			default: ;
		endcase
	endfunction

	function void check(out_item_t got);
		out_item_t exp_w;
		if (expected_weights.size() == 0) begin
			$error("unexpected weight transaction idx=%0d val=%0d",
				got.weight_index, got.weight_value);
			errors++;
			return;
		end
		exp_w = expected_weights.pop_front();
		if (got.weight_index !== exp_w.weight_index) begin
			$error("weight_index exp %0d got %0d", exp_w.weight_index, got.weight_index);
			errors++;
		end
		if (got.weight_value !== exp_w.weight_value) begin
			$error("weight_value exp %0d got %0d", exp_w.weight_value, got.weight_value);
			errors++;
		end
		if (got.last_weight !== exp_w.last_weight) begin
			$error("last_weight exp %0d got %0d", exp_w.last_weight, got.last_weight);
			errors++;
		end
	endfunction
endclass

module tb_poly_sigmoid_logreg_gd_step;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 120;
	localparam int MAX_POS = 32'h7fffffff;
	localparam int MAX_NEG = 32'h80000000;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	in_item_t sample;
	logic weight_valid;
	logic weight_stall;
	out_item_t weight;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	weight_scoreboard sb;
	int cycles;
	int num_items;
	bit quiet;
	int stall_left;

	poly_sigmoid_logreg_gd_step #(.DIM(16)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.weight_valid(weight_valid),
		.weight_stall(weight_stall),
		.weight(weight),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		weight_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		num_items = 0;
		quiet = 1'b0;
		stall_left = 0;
		sb = new();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && weight_valid && !weight_stall)
			sb.check(weight);

	// receiver back-pressure in short bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			weight_stall = 1'b1;
		end else if (!quiet && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 3);
			weight_stall = 1'b1;
		end else begin
			weight_stall = 1'b0;
		end
	end

	task automatic send_item(input logic [1:0] op, input int fv, input logic lf);
		in_item_t it;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			sample_valid = 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		it.op = op;
		it.feature_value = fv;
		it.last_feature = lf;
		@(negedge clk);
		sample_valid = 1'b1;
		sample = it;
		do @(posedge clk); while (sample_stall);
		sb.note_input(it);
		if (op != OP_RSVD)
			num_items++;
	endtask

	// lets the block go idle: all weights back, then time for any silent work
	task automatic drain();
		@(negedge clk);
		sample_valid = 1'b0;
		while (sb.expected_weights.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int rnd_feature();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
			default: return int'($urandom_range(0, 32'h4000000)) - 32'h2000000;
		endcase
	endfunction

	function automatic int rnd_q(input int span);
		case ($urandom_range(0, 7))
			0: return MAX_POS;
			1: return MAX_NEG;
			2: return 0;
			3: return $urandom;
			default: return int'($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	task automatic send_sample(input int len);
		for (int k = 1; k <= len; k++)
			send_item(OP_FEAT, rnd_feature(), k == len);
	endtask

	initial begin
		int mode_sel;
		#1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one update with reset settings, then a tuned polynomial
		send_item(OP_FEAT, 32'h01000000, 1'b1);
		send_item(OP_EOB, 0, 1'b0);
		drain();
		write_cfg(CFG_MODE, 32'd0);
		write_cfg(CFG_STEP, 32'h00400000);
		write_cfg(CFG_ETA, 32'h00800000);
		write_cfg(CFG_C0, 32'h00800000);
		write_cfg(CFG_C1, 32'h00400000);
		write_cfg(CFG_C3, 32'hFFFAAAAB);
		write_cfg(CFG_C5, 32'h00002000);
		write_cfg(CFG_C7, 32'hFFFFFF80);
		send_item(OP_FEAT, MAX_POS, 1'b0);
		send_item(OP_FEAT, MAX_NEG, 1'b0);
		send_item(OP_FEAT, 32'h00000001, 1'b1);
		// sample longer than the weight vector
		for (int k = 0; k < 18; k++)
			send_item(OP_FEAT, 32'h00100000 * (k - 9), k == 17);
		send_item(OP_RSVD, 32'hFFFFFFFF, 1'b1);
		send_item(OP_EOB, 0, 1'b1);
		// partial sample thrown away by end of batch
		send_item(OP_FEAT, 32'h00200000, 1'b0);
		send_item(OP_EOB, 0, 1'b0);
		send_item(OP_CLR, 0, 1'b1);
		send_item(OP_FEAT, 32'hFFF00000, 1'b1);
		send_item(OP_EOB, 0, 1'b0);

		for (int phase = 0; num_items < 220; phase++) begin
			drain();
			if (num_items >= 180)
				quiet = 1'b1;
			mode_sel = phase % 4;
			write_cfg(CFG_MODE, mode_sel);
			write_cfg(CFG_STEP, phase == 1 ? MAX_POS : phase == 2 ? MAX_NEG
				: rnd_q(32'h01000000));
			write_cfg(CFG_ETA, phase == 3 ? MAX_POS : phase == 4 ? MAX_NEG
				: int'($urandom_range(0, 32'h01000000)));
			write_cfg(CFG_C0, rnd_q(32'h01000000));
			write_cfg(CFG_C1, rnd_q(32'h00800000));
			write_cfg(CFG_C3, rnd_q(32'h00100000));
			write_cfg(CFG_C5, rnd_q(32'h00010000));
			write_cfg(CFG_C7, rnd_q(32'h00001000));
			repeat ($urandom_range(1, 3)) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 9) == 0)
						send_sample($urandom_range(17, 20));
					else
						send_sample($urandom_range(1, 16));
				end
				case ($urandom_range(0, 9))
					0: send_item(OP_CLR, $urandom, $urandom_range(0, 1));
					1: send_item(OP_RSVD, $urandom, $urandom_range(0, 1));
					2: send_item(OP_FEAT, rnd_feature(), 1'b0);
					default: ;
				endcase
				send_item(OP_EOB, $urandom, $urandom_range(0, 1));
			end
		end

		drain();
		if (sb.errors == 0 && sb.expected_weights.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/psl_pkg.sv
rtl/psl_cell.sv
rtl/poly_sigmoid_logreg_gd_step.sv
tb/sv/tb_poly_sigmoid_logreg_gd_step.sv
